// ----- design/pid_controller_antiwindup_macros.svh -----
// assertion helpers shared by the error and output modules
`ifndef PID_CONTROLLER_ANTIWINDUP_MACROS_SVH
`define PID_CONTROLLER_ANTIWINDUP_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, off while reset is held
`define PIDAW_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pidaw: same-cycle check failed");
// next-cycle implication, off while reset is held
`define PIDAW_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pidaw: next-cycle check failed");
`else
`define PIDAW_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define PIDAW_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- design/pidaw_pkg.sv -----
`default_nettype none
package pidaw_pkg;

    localparam int MEAS_W   = 24;
    localparam int ERR_W    = 25;
    localparam int SUM_W    = 40;
    localparam int OPD_W    = 27;
    localparam int GAIN_W   = 32;
    localparam int DRIVE_W  = 16;
    localparam int QSAT_W   = 18;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [14:0] DRIVE_MAX_RESET = 15'd16000;

    // mode_flags bit positions
    localparam int MODE_INC = 0;
    localparam int MODE_LIM = 1;
    localparam int MODE_SEP = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SETPOINT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SUM_LIMIT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SEP_LIMIT = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DRIVE_MAX = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_MODE      = 3'd7;

    typedef struct packed {
        logic signed [GAIN_W-1:0] gain_p;
        logic signed [GAIN_W-1:0] gain_i;
        logic signed [GAIN_W-1:0] gain_d;
        logic signed [MEAS_W-1:0] setpoint;
        logic [30:0]              sum_limit;
        logic [ERR_W-1:0]         sep_limit;
        logic [14:0]              drive_max;
        logic [2:0]               mode;
    } t_cfg;

    // multiplier operands for the p, i and d terms
    typedef struct packed {
        logic signed [OPD_W-1:0] ap;
        logic signed [SUM_W-1:0] ai;
        logic signed [OPD_W-1:0] ad;
    } t_ops;

endpackage
`default_nettype wire

// ----- design/pid_controller_antiwindup.sv -----
// PID controller with integral separation, accumulator clamping and drive clamping.
// Channels:
//   s_*   one measurement request per sample, accepted when s_tvalid and s_tready are high
//   m_*   one drive result per measurement, in order; m_tuser flags a clamped drive
//   cfg_* register writes (index 0..7: gain_p, gain_i, gain_d, setpoint, sum_limit,
//         separation_limit, drive_max, mode_flags); cfg_ready is always high
// Each result passes the measurement, operand, multiply and result registers to m_tvalid.
// Throughput: one measurement per cycle while m_tready is high; the loops that carry
//   state from sample to sample (error accumulator and held drive) each close through a
//   register of their own, and the gain multiplies run in a pipeline between them.
// Reset (synchronous, active low): gains, setpoint and limits go to zero, drive_max to
//   16000, mode to positional with no limiting; accumulator, past errors and held drive
//   clear, and the pipeline empties.
// Stall: every stage has its own valid bit, so while m_tready is low the pipeline still
//   takes new measurements until all stages are full; s_tready then drops.
// Write registers only while no request is in flight.
`default_nettype none
module pid_controller_antiwindup (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // measurement stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,    // [23:0] measurement
    // drive stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,    // [15:0] drive
    output logic             m_tuser,    // [0] clamped
    // register writes
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);
    import pidaw_pkg::*;

    t_cfg                     r_cfg;

    // error stage to multiply pipeline
    logic                     w_ops_valid;
    logic                     w_ops_ready;
    t_ops                     w_ops;

    // multiply pipeline to output stage
    logic                     w_q_valid;
    logic                     w_q_ready;
    logic signed [QSAT_W-1:0] w_q;

    assign cfg_ready = 1'b1;

    // register file; every index names a register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain_p    <= '0;
            r_cfg.gain_i    <= '0;
            r_cfg.gain_d    <= '0;
            r_cfg.setpoint  <= '0;
            r_cfg.sum_limit <= '0;
            r_cfg.sep_limit <= '0;
            r_cfg.drive_max <= DRIVE_MAX_RESET;
            r_cfg.mode      <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_GAIN_P:    r_cfg.gain_p    <= cfg_data;
                REG_GAIN_I:    r_cfg.gain_i    <= cfg_data;
                REG_GAIN_D:    r_cfg.gain_d    <= cfg_data;
                REG_SETPOINT:  r_cfg.setpoint  <= cfg_data[MEAS_W-1:0];
                REG_SUM_LIMIT: r_cfg.sum_limit <= cfg_data[30:0];
                REG_SEP_LIMIT: r_cfg.sep_limit <= cfg_data[ERR_W-1:0];
                REG_DRIVE_MAX: r_cfg.drive_max <= cfg_data[14:0];
                REG_MODE:      r_cfg.mode      <= cfg_data[2:0];
            endcase
        end
    end

    // error, accumulator update and operand select
    pidaw_err u_err (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (s_tvalid),
        .o_ready (s_tready),
        .i_meas  (s_tdata),
        .o_valid (w_ops_valid),
        .i_ready (w_ops_ready),
        .o_ops   (w_ops)
    );

    // gain products, exact sum, truncation toward zero and saturation to +-65536
    pidaw_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (w_ops_valid),
        .o_ready (w_ops_ready),
        .i_ops   (w_ops),
        .o_valid (w_q_valid),
        .i_ready (w_q_ready),
        .o_q     (w_q)
    );

    // held-drive add in incremental mode, drive clamp and result register
    pidaw_out u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_valid    (w_q_valid),
        .o_ready    (w_q_ready),
        .i_q        (w_q),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_drive    (m_tdata),
        .o_clamped  (m_tuser)
    );

endmodule
`default_nettype wire

// ----- design/pidaw_err.sv -----
`default_nettype none
`include "pid_controller_antiwindup_macros.svh"
module pidaw_err (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire pidaw_pkg::t_cfg  i_cfg,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire logic [23:0]      i_meas,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output pidaw_pkg::t_ops       o_ops
);
    import pidaw_pkg::*;

    logic                    r_v1;
    logic signed [MEAS_W-1:0] r_meas;
    logic                    r_v2;
    t_ops                    r_ops;

    logic signed [SUM_W-1:0] r_error_sum;
    logic signed [ERR_W-1:0] r_prev;
    logic signed [ERR_W-1:0] r_pprev;

    logic                    w_can1;
    logic                    w_can2;
    logic                    w_load;

    logic signed [ERR_W-1:0] w_e;
    logic [ERR_W-1:0]        w_abs_e;
    logic [SUM_W-1:0]        w_abs_es;
    logic signed [SUM_W:0]   w_sum;
    logic signed [SUM_W:0]   w_lim;
    logic                    w_same;
    logic                    w_sep_skip;
    logic signed [SUM_W-1:0] n_error_sum;
    logic signed [ERR_W:0]   w_d1;
    logic signed [OPD_W-1:0] w_d2;
    t_ops                    n_ops;

    assign w_can2  = !r_v2 || i_ready;
    assign w_can1  = !r_v1 || w_can2;
    assign w_load  = r_v1 && w_can2;
    assign o_ready = w_can1;
    assign o_valid = r_v2;
    assign o_ops   = r_ops;

    always_comb begin
        w_e      = ERR_W'($signed(i_cfg.setpoint)) - ERR_W'($signed(r_meas));
        w_abs_e  = w_e[ERR_W-1] ? ERR_W'(-w_e) : ERR_W'(w_e);
        w_abs_es = r_error_sum[SUM_W-1] ? SUM_W'(-r_error_sum) : SUM_W'(r_error_sum);
        w_sum    = (SUM_W+1)'(r_error_sum) + (SUM_W+1)'(w_e);
        w_lim    = $signed({(SUM_W+1-31)'(0), i_cfg.sum_limit});
        w_same   = (!r_error_sum[SUM_W-1] && r_error_sum != '0 && !w_e[ERR_W-1] && w_e != '0)
                || (r_error_sum[SUM_W-1] && w_e[ERR_W-1]);
        w_sep_skip = i_cfg.mode[MODE_SEP] && (w_abs_e >= i_cfg.sep_limit);

        n_error_sum = r_error_sum;
        if (!i_cfg.mode[MODE_INC] && !w_sep_skip) begin
            if (i_cfg.mode[MODE_LIM]) begin
                if (!((w_abs_es >= SUM_W'(i_cfg.sum_limit)) && w_same)) begin
                    priority if (w_sum > w_lim) begin
                        n_error_sum = SUM_W'(w_lim);
                    end else if (w_sum < -w_lim) begin
                        n_error_sum = SUM_W'(-w_lim);
                    end else begin
                        n_error_sum = SUM_W'(w_sum);
                    end
                end
            end else begin
                // saturate at the accumulator range
                if (w_sum[SUM_W] != w_sum[SUM_W-1]) begin
                    n_error_sum = {w_sum[SUM_W], {(SUM_W-1){!w_sum[SUM_W]}}};
                end else begin
                    n_error_sum = SUM_W'(w_sum);
                end
            end
        end

        w_d1 = (ERR_W+1)'(w_e) - (ERR_W+1)'(r_prev);
        w_d2 = OPD_W'(w_e) - (OPD_W'(r_prev) <<< 1) + OPD_W'(r_pprev);

        if (i_cfg.mode[MODE_INC]) begin
            n_ops.ap = OPD_W'(w_d1);
            n_ops.ai = SUM_W'(w_e);
            n_ops.ad = w_d2;
        end else begin
            n_ops.ap = OPD_W'(w_e);
            n_ops.ai = n_error_sum;
            n_ops.ad = OPD_W'(w_d1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_error_sum <= '0;
            r_prev      <= '0;
            r_pprev     <= '0;
        end else begin
            if (w_can1) begin
                r_v1 <= i_valid;
            end
            if (w_can2) begin
                r_v2 <= r_v1;
            end
            if (w_load) begin
                r_error_sum <= n_error_sum;
                r_prev      <= w_e;
                if (i_cfg.mode[MODE_INC]) begin
                    r_pprev <= r_prev;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_can1 && i_valid) begin
            r_meas <= i_meas;
        end
        if (w_load) begin
            r_ops <= n_ops;
        end
    end

    `PIDAW_ASSERT_NXT(a_inc_keeps_sum, i_clk, i_rst_n, w_load && i_cfg.mode[MODE_INC], r_error_sum == $past(r_error_sum))
    `PIDAW_ASSERT_NXT(a_pos_keeps_pprev, i_clk, i_rst_n, w_load && !i_cfg.mode[MODE_INC], r_pprev == $past(r_pprev))
    `PIDAW_ASSERT_IMP(a_stage_order, i_clk, i_rst_n, r_v2 && !i_ready, !w_load)

endmodule
`default_nettype wire

// ----- design/pidaw_mac.sv -----
`default_nettype none
module pidaw_mac (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire pidaw_pkg::t_cfg  i_cfg,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire pidaw_pkg::t_ops  i_ops,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output logic signed [17:0]    o_q
);
    import pidaw_pkg::*;

    localparam int PPD_W = GAIN_W + OPD_W;      // p and d products
    localparam int PHI_W = GAIN_W + SUM_W - 16; // gain_i times upper sum bits
    localparam int PLO_W = GAIN_W + 17;         // gain_i times lower 16 bits
    localparam int SPD_W = PPD_W + 1;
    localparam int SI_W  = PHI_W + 17;
    localparam int TOT_W = SI_W + 1;
    localparam int Q_W   = TOT_W - 16;

    logic [3:0]               r_v;
    logic [3:0]               w_can;

    logic signed [PPD_W-1:0]  r_pp;
    logic signed [PPD_W-1:0]  r_pd;
    logic signed [PHI_W-1:0]  r_phi;
    logic signed [PLO_W-1:0]  r_plo;
    logic signed [SPD_W-1:0]  r_spd;
    logic signed [SI_W-1:0]   r_si;
    logic signed [TOT_W-1:0]  r_tot;
    logic signed [QSAT_W-1:0] r_q;

    logic signed [16:0]       w_lo;
    logic signed [SUM_W-17:0] w_hi;
    logic signed [Q_W-1:0]    w_q;
    logic signed [QSAT_W-1:0] n_q;

    localparam logic signed [Q_W-1:0] Q_MAX = Q_W'(65536);

    assign w_can[3] = !r_v[3] || i_ready;
    assign w_can[2] = !r_v[2] || w_can[3];
    assign w_can[1] = !r_v[1] || w_can[2];
    assign w_can[0] = !r_v[0] || w_can[1];
    assign o_ready  = w_can[0];
    assign o_valid  = r_v[3];
    assign o_q      = r_q;

    assign w_lo = $signed({1'b0, i_ops.ai[15:0]});
    assign w_hi = i_ops.ai[SUM_W-1:16];

    always_comb begin
        // truncate toward zero: floor, then step up for negative with a fraction
        w_q = r_tot[TOT_W-1:16] + Q_W'(r_tot[TOT_W-1] && (r_tot[15:0] != '0));
        priority if (w_q > Q_MAX) begin
            n_q = QSAT_W'(Q_MAX);
        end else if (w_q < -Q_MAX) begin
            n_q = QSAT_W'(-Q_MAX);
        end else begin
            n_q = QSAT_W'(w_q);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_can[0]) r_v[0] <= i_valid;
            if (w_can[1]) r_v[1] <= r_v[0];
            if (w_can[2]) r_v[2] <= r_v[1];
            if (w_can[3]) r_v[3] <= r_v[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_can[0] && i_valid) begin
            r_pp  <= i_cfg.gain_p * i_ops.ap;
            r_pd  <= i_cfg.gain_d * i_ops.ad;
            r_phi <= i_cfg.gain_i * w_hi;
            r_plo <= i_cfg.gain_i * w_lo;
        end
        if (w_can[1] && r_v[0]) begin
            r_spd <= SPD_W'(r_pp) + SPD_W'(r_pd);
            r_si  <= SI_W'($signed({r_phi, 16'b0})) + SI_W'(r_plo);
        end
        if (w_can[2] && r_v[1]) begin
            r_tot <= TOT_W'(r_spd) + TOT_W'(r_si);
        end
        if (w_can[3] && r_v[2]) begin
            r_q <= n_q;
        end
    end

endmodule
`default_nettype wire

// ----- design/pidaw_out.sv -----
`default_nettype none
`include "pid_controller_antiwindup_macros.svh"
module pidaw_out (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire pidaw_pkg::t_cfg  i_cfg,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire logic signed [17:0] i_q,
    output logic                  o_m_tvalid,
    input  wire logic             i_m_tready,
    output logic [15:0]           o_drive,
    output logic                  o_clamped
);
    import pidaw_pkg::*;

    localparam int V_W = QSAT_W + 1;

    logic                      r_ov;
    logic signed [DRIVE_W-1:0] r_drive;
    logic                      r_clamped;
    logic signed [DRIVE_W-1:0] r_held;

    logic                      w_can;
    logic                      w_load;
    logic signed [V_W-1:0]     w_v;
    logic signed [V_W-1:0]     w_max;
    logic signed [DRIVE_W-1:0] w_dmax;
    logic signed [DRIVE_W-1:0] n_drive;
    logic                      n_clamped;

    assign w_can      = !r_ov || i_m_tready;
    assign w_load     = i_valid && w_can;
    assign o_ready    = w_can;
    assign o_m_tvalid = r_ov;
    assign o_drive    = r_drive;
    assign o_clamped  = r_clamped;
    assign w_dmax     = $signed({1'b0, i_cfg.drive_max});

    always_comb begin
        w_max = V_W'(w_dmax);
        w_v   = V_W'(i_q) + (i_cfg.mode[MODE_INC] ? V_W'(r_held) : V_W'(0));
        priority if (w_v > w_max) begin
            n_drive   = w_dmax;
            n_clamped = 1'b1;
        end else if (w_v < -w_max) begin
            n_drive   = -w_dmax;
            n_clamped = 1'b1;
        end else begin
            n_drive   = DRIVE_W'(w_v);
            n_clamped = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov   <= 1'b0;
            r_held <= '0;
        end else begin
            if (w_can) begin
                r_ov <= i_valid;
            end
            if (w_load) begin
                r_held <= n_drive;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_drive   <= n_drive;
            r_clamped <= n_clamped;
        end
    end

    `PIDAW_ASSERT_IMP(a_drive_in_range, i_clk, i_rst_n, r_ov, (r_drive <= w_dmax) && (r_drive >= -w_dmax))
    `PIDAW_ASSERT_IMP(a_clamp_at_edge, i_clk, i_rst_n, r_ov && r_clamped, (r_drive == w_dmax) || (r_drive == -w_dmax))
    `PIDAW_ASSERT_IMP(a_held_tracks_out, i_clk, i_rst_n, r_ov, r_held == r_drive)

endmodule
`default_nettype wire
